>>> design/utcl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utcl_pkg
// Shared types and tables for the utc to local calendar converter.
// ----------------------------------------------------------------------------
package utcl_pkg;

  // number of register stages from input to result register
  localparam int NUM_STAGES = 10;

  typedef struct packed {
    logic [11:0] utc_year;
    logic [3:0]  utc_month;
    logic [4:0]  utc_day;
    logic [4:0]  utc_hour;
    logic [5:0]  utc_minute;
    logic [5:0]  utc_second;
  } utcl_in_t;

  typedef struct packed {
    logic [11:0] local_year;
    logic [3:0]  local_month;
    logic [4:0]  local_day;
    logic [4:0]  local_hour;
    logic [5:0]  local_minute;
    logic [5:0]  local_second;
    logic [2:0]  weekday;
  } utcl_out_t;

  // per-stage load enables and valid flags
  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
    logic [NUM_STAGES-1:0] valid;
  } utcl_pipe_t;

  // days from march 1 to the first of the month, month counted from march
  function automatic logic [8:0] month_offset(input logic [3:0] mshift);
    logic [8:0] days;
    case (mshift)
      4'd0:    days = 9'd0;
      4'd1:    days = 9'd31;
      4'd2:    days = 9'd61;
      4'd3:    days = 9'd92;
      4'd4:    days = 9'd122;
      4'd5:    days = 9'd153;
      4'd6:    days = 9'd184;
      4'd7:    days = 9'd214;
      4'd8:    days = 9'd245;
      4'd9:    days = 9'd275;
      4'd10:   days = 9'd306;
      4'd11:   days = 9'd337;
      4'd12:   days = 9'd367;
      default: days = 9'd0;
    endcase
    return days;
  endfunction

endpackage
`default_nettype wire

>>> design/utc_to_local_calendar.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utc_to_local_calendar
// Converts a utc calendar time stamp to local civil date, time and weekday
// using a configurable zone offset in quarter hours.
// ----------------------------------------------------------------------------
//
//  channel   ports                        moves
//  -------   --------------------------   ----------------------------------
//  in        in_valid/in_ready/in_data    one utc time stamp per request
//  out       out_valid/out_ready/out_data one local date, time and weekday
//  cfg       cfg_wr_en/cfg_wr_data        zone offset, signed quarter hours
//
//  - one request per cycle sustained while out_ready is high; out_valid
//    rises once a request has passed through all ten register stages of
//    the date datapath, which hold constant multiplies, compares and adds
//  - rst_n (synchronous) empties the pipeline and clears the zone offset
//  - a stalled output holds its result; stages behind it keep filling any
//    bubbles, so in_ready drops only when all ten stages hold a request
//    and out_ready is low
//
// date path: the day count is kept offset by 719468 + 146097 so it is never
// negative, split into 400-year era, year, day of year, month and day by
// reciprocal multiplies; time of day is handled apart and only moves the day
// count by -1, 0 or +1
// ----------------------------------------------------------------------------
module utc_to_local_calendar (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  utcl_pkg::utcl_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output utcl_pkg::utcl_out_t  out_data,
  input  logic                 cfg_wr_en,
  input  logic signed [6:0]    cfg_wr_data
);
  import utcl_pkg::*;

  localparam logic [18:0] SEC_PER_DAY = 19'd86400;

  utcl_pipe_t ctrl;

  utcl_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .ctrl      (ctrl)
  );

  // zone offset register
  logic signed [6:0] zone_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_r <= '0;
    end else if (cfg_wr_en) begin
      zone_r <= cfg_wr_data;
    end
  end

  // --------------------------------------------------------------------------
  // stage 0: shifted year, day of (march-based) year, signed time of day
  // --------------------------------------------------------------------------
  logic              month_low;
  logic [3:0]        mshift;
  logic [8:0]        moff0;
  logic [16:0]       hour_sec;
  logic [11:0]       min_sec;
  logic signed [16:0] zone_sec;
  logic [12:0]       s0_u_nxt;
  logic [9:0]        s0_diy_nxt;
  logic [18:0]       s0_tod_nxt;
  logic [12:0]       s0_u_r;
  logic [9:0]        s0_diy_r;
  logic [18:0]       s0_tod_r;

  always_comb begin
    // january and february count as months of the previous year
    month_low  = (in_data.utc_month <= 4'd2);
    s0_u_nxt   = {1'b0, in_data.utc_year} + 13'd400 - {12'b0, month_low};
    mshift     = month_low ? in_data.utc_month + 4'd9 : in_data.utc_month - 4'd3;
    moff0      = month_offset(mshift);
    s0_diy_nxt = {1'b0, moff0} + {5'b0, in_data.utc_day} - 10'd1;
    hour_sec   = {12'b0, in_data.utc_hour} * 17'd3600;
    min_sec    = {6'b0, in_data.utc_minute} * 12'd60;
    zone_sec   = $signed({{10{zone_r[6]}}, zone_r}) * 17'sd900;
    s0_tod_nxt = {2'b0, hour_sec} + {7'b0, min_sec} + {13'b0, in_data.utc_second}
               + {{2{zone_sec[16]}}, zone_sec};
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[0]) begin
      s0_u_r   <= s0_u_nxt;
      s0_diy_r <= s0_diy_nxt;
      s0_tod_r <= s0_tod_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: year days, century count, day carry from time of day
  // --------------------------------------------------------------------------
  logic [24:0] q_prod;
  logic [18:0] rem_full;
  logic [20:0] s1_yd_nxt;
  logic [5:0]  s1_q100_nxt;
  logic [1:0]  s1_shift_nxt;
  logic [20:0] s1_yd_r;
  logic [5:0]  s1_q100_r;
  logic [10:0] s1_u4_r;
  logic [9:0]  s1_diy_r;
  logic [1:0]  s1_shift_r;
  logic [16:0] s1_rem_r;

  always_comb begin
    s1_yd_nxt   = {8'b0, s0_u_r} * 21'd365;
    // year / 100 by reciprocal
    q_prod      = {12'b0, s0_u_r} * 25'd5243;
    s1_q100_nxt = q_prod[24:19];
    if (s0_tod_r[18]) begin
      s1_shift_nxt = 2'b11;
      rem_full     = s0_tod_r + SEC_PER_DAY;
    end else if (s0_tod_r >= SEC_PER_DAY) begin
      s1_shift_nxt = 2'b01;
      rem_full     = s0_tod_r - SEC_PER_DAY;
    end else begin
      s1_shift_nxt = 2'b00;
      rem_full     = s0_tod_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[1]) begin
      s1_yd_r    <= s1_yd_nxt;
      s1_q100_r  <= s1_q100_nxt;
      s1_u4_r    <= s0_u_r[12:2];
      s1_diy_r   <= s0_diy_r;
      s1_shift_r <= s1_shift_nxt;
      s1_rem_r   <= rem_full[16:0];
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: biased day count, local hour
  // --------------------------------------------------------------------------
  logic [22:0] w_sum;
  logic [24:0] h_prod;
  logic [20:0] s2_w_r;
  logic [4:0]  s2_hour_r;
  logic [16:0] s2_rem_r;

  always_comb begin
    w_sum  = {2'b0, s1_yd_r} + {12'b0, s1_u4_r} - {17'b0, s1_q100_r}
           + {19'b0, s1_q100_r[5:2]} + {{13{s1_diy_r[9]}}, s1_diy_r}
           + {{21{s1_shift_r[1]}}, s1_shift_r};
    // hour = (rem / 16) / 225
    h_prod = {12'b0, s1_rem_r[16:4]} * 25'd4661;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[2]) begin
      s2_w_r    <= w_sum[20:0];
      s2_hour_r <= h_prod[24:20];
      s2_rem_r  <= s1_rem_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: era, weekday, seconds within the hour
  // --------------------------------------------------------------------------
  logic [41:0] e_prod;
  logic [5:0]  dig_sum;
  logic [3:0]  fold1;
  logic [3:0]  fold2;
  logic [2:0]  wd_mod;
  logic [16:0] hsec3;
  logic [16:0] r1_full;
  logic [3:0]  s3_era_r;
  logic [2:0]  s3_wd_r;
  logic [20:0] s3_w_r;
  logic [4:0]  s3_hour_r;
  logic [11:0] s3_r1_r;

  always_comb begin
    e_prod  = {21'b0, s2_w_r} * 42'd1881476;
    // 8 is 1 mod 7: sum octal digits, plus 2 aligns the bias to monday = 0
    dig_sum = 6'd2;
    for (int g = 0; g < 7; g++) begin
      dig_sum = dig_sum + {3'b0, s2_w_r[3*g +: 3]};
    end
    fold1   = {1'b0, dig_sum[5:3]} + {1'b0, dig_sum[2:0]};
    fold2   = {3'b0, fold1[3]} + {1'b0, fold1[2:0]};
    wd_mod  = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];
    hsec3   = {12'b0, s2_hour_r} * 17'd3600;
    r1_full = s2_rem_r - hsec3;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[3]) begin
      s3_era_r  <= e_prod[41:38];
      s3_wd_r   <= wd_mod + 3'd1;
      s3_w_r    <= s2_w_r;
      s3_hour_r <= s2_hour_r;
      s3_r1_r   <= r1_full[11:0];
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: day of era, local minute
  // --------------------------------------------------------------------------
  logic [20:0] era_days;
  logic [20:0] doe_full;
  logic [19:0] m_prod;
  logic [17:0] s4_doe_r;
  logic [3:0]  s4_era_r;
  logic [2:0]  s4_wd_r;
  logic [4:0]  s4_hour_r;
  logic [5:0]  s4_min_r;
  logic [11:0] s4_r1_r;

  always_comb begin
    era_days = {17'b0, s3_era_r} * 21'd146097;
    doe_full = s3_w_r - era_days;
    // minute = (r1 / 4) / 15
    m_prod   = {10'b0, s3_r1_r[11:2]} * 20'd1093;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[4]) begin
      s4_doe_r  <= doe_full[17:0];
      s4_era_r  <= s3_era_r;
      s4_wd_r   <= s3_wd_r;
      s4_hour_r <= s3_hour_r;
      s4_min_r  <= m_prod[19:14];
      s4_r1_r   <= s3_r1_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: leap corrected day count, local second
  // --------------------------------------------------------------------------
  logic [30:0] a_prod;
  logic [2:0]  cent_cnt;
  logic        era_last;
  logic [17:0] n_full;
  logic [11:0] msec5;
  logic [11:0] sec_full;
  logic [17:0] s5_n_r;
  logic [17:0] s5_doe_r;
  logic [3:0]  s5_era_r;
  logic [2:0]  s5_wd_r;
  logic [4:0]  s5_hour_r;
  logic [5:0]  s5_min_r;
  logic [5:0]  s5_sec_r;

  always_comb begin
    // doe / 1460 = (doe / 4) / 365
    a_prod   = {15'b0, s4_doe_r[17:2]} * 31'd45965;
    cent_cnt = {2'b0, s4_doe_r >= 18'd36524} + {2'b0, s4_doe_r >= 18'd73048}
             + {2'b0, s4_doe_r >= 18'd109572} + {2'b0, s4_doe_r >= 18'd146096};
    era_last = (s4_doe_r == 18'd146096);
    n_full   = s4_doe_r - {11'b0, a_prod[30:24]} + {15'b0, cent_cnt}
             - {17'b0, era_last};
    msec5    = {6'b0, s4_min_r} * 12'd60;
    sec_full = s4_r1_r - msec5;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[5]) begin
      s5_n_r    <= n_full;
      s5_doe_r  <= s4_doe_r;
      s5_era_r  <= s4_era_r;
      s5_wd_r   <= s4_wd_r;
      s5_hour_r <= s4_hour_r;
      s5_min_r  <= s4_min_r;
      s5_sec_r  <= sec_full[5:0];
    end
  end

  // --------------------------------------------------------------------------
  // stage 6: year of era
  // --------------------------------------------------------------------------
  logic [34:0] y_prod;
  logic [8:0]  s6_yoe_r;
  logic [17:0] s6_doe_r;
  logic [3:0]  s6_era_r;
  logic [2:0]  s6_wd_r;
  logic [4:0]  s6_hour_r;
  logic [5:0]  s6_min_r;
  logic [5:0]  s6_sec_r;

  always_comb begin
    y_prod = {17'b0, s5_n_r} * 35'd183861;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[6]) begin
      s6_yoe_r  <= y_prod[34:26];
      s6_doe_r  <= s5_doe_r;
      s6_era_r  <= s5_era_r;
      s6_wd_r   <= s5_wd_r;
      s6_hour_r <= s5_hour_r;
      s6_min_r  <= s5_min_r;
      s6_sec_r  <= s5_sec_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 7: day of (march-based) year
  // --------------------------------------------------------------------------
  logic [1:0]  c100;
  logic [17:0] yoe_days;
  logic [17:0] diy_full;
  logic [8:0]  s7_diy_r;
  logic [8:0]  s7_yoe_r;
  logic [3:0]  s7_era_r;
  logic [2:0]  s7_wd_r;
  logic [4:0]  s7_hour_r;
  logic [5:0]  s7_min_r;
  logic [5:0]  s7_sec_r;

  always_comb begin
    c100     = {1'b0, s6_yoe_r >= 9'd100} + {1'b0, s6_yoe_r >= 9'd200}
             + {1'b0, s6_yoe_r >= 9'd300};
    yoe_days = {9'b0, s6_yoe_r} * 18'd365 + {11'b0, s6_yoe_r[8:2]} - {16'b0, c100};
    diy_full = s6_doe_r - yoe_days;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[7]) begin
      s7_diy_r  <= diy_full[8:0];
      s7_yoe_r  <= s6_yoe_r;
      s7_era_r  <= s6_era_r;
      s7_wd_r   <= s6_wd_r;
      s7_hour_r <= s6_hour_r;
      s7_min_r  <= s6_min_r;
      s7_sec_r  <= s6_sec_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 8: month counted from march
  // --------------------------------------------------------------------------
  logic [10:0] mp_arg;
  logic [21:0] mp_prod;
  logic [3:0]  s8_mp_r;
  logic [8:0]  s8_diy_r;
  logic [8:0]  s8_yoe_r;
  logic [3:0]  s8_era_r;
  logic [2:0]  s8_wd_r;
  logic [4:0]  s8_hour_r;
  logic [5:0]  s8_min_r;
  logic [5:0]  s8_sec_r;

  always_comb begin
    // (5 * diy + 2) / 153
    mp_arg  = {s7_diy_r, 2'b0} + {2'b0, s7_diy_r} + 11'd2;
    mp_prod = {11'b0, mp_arg} * 22'd1714;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[8]) begin
      s8_mp_r   <= mp_prod[21:18];
      s8_diy_r  <= s7_diy_r;
      s8_yoe_r  <= s7_yoe_r;
      s8_era_r  <= s7_era_r;
      s8_wd_r   <= s7_wd_r;
      s8_hour_r <= s7_hour_r;
      s8_min_r  <= s7_min_r;
      s8_sec_r  <= s7_sec_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 9: result register with civil month, day and year
  // --------------------------------------------------------------------------
  logic [8:0]  moff9;
  logic [8:0]  day_full;
  logic [3:0]  month_out;
  logic        jan_feb;
  logic [12:0] year_full;
  utcl_out_t   out_nxt;
  utcl_out_t   out_r;

  always_comb begin
    moff9     = month_offset(s8_mp_r);
    day_full  = s8_diy_r - moff9 + 9'd1;
    month_out = (s8_mp_r < 4'd10) ? s8_mp_r + 4'd3 : s8_mp_r - 4'd9;
    jan_feb   = (month_out <= 4'd2);
    // era is biased by one, hence the 400 taken off; wraps modulo 4096
    year_full = {4'b0, s8_yoe_r} + {9'b0, s8_era_r} * 13'd400 - 13'd400
              + {12'b0, jan_feb};
    out_nxt.local_year   = year_full[11:0];
    out_nxt.local_month  = month_out;
    out_nxt.local_day    = day_full[4:0];
    out_nxt.local_hour   = s8_hour_r;
    out_nxt.local_minute = s8_min_r;
    out_nxt.local_second = s8_sec_r;
    out_nxt.weekday      = s8_wd_r;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[9]) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = ctrl.valid[NUM_STAGES-1];
  assign out_data  = out_r;

endmodule
`default_nettype wire

>>> design/utcl_pipe_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utcl_pipe_ctrl
// Valid tracking and bubble-collapsing load enables for the datapath stages.
// ----------------------------------------------------------------------------
module utcl_pipe_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                out_ready,
  output logic                in_ready,
  output utcl_pkg::utcl_pipe_t ctrl
);
  import utcl_pkg::*;

  logic [NUM_STAGES-1:0] valid_r;
  logic [NUM_STAGES-1:0] valid_nxt;
  logic [NUM_STAGES-1:0] load;

  // a stage may load when the output drains or some stage at or after it is empty
  always_comb begin
    logic [NUM_STAGES-1:0] low_mask;
    for (int k = 0; k < NUM_STAGES; k++) begin
      low_mask = NUM_STAGES'((1 << k) - 1);
      load[k]  = out_ready || !(&(valid_r | low_mask));
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_STAGES; k++) begin
      if (load[k]) begin
        valid_nxt[k] = (k == 0) ? in_valid : valid_r[(k == 0) ? 0 : k - 1];
      end else begin
        valid_nxt[k] = valid_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_ready   = load[0];
  assign ctrl.load  = load;
  assign ctrl.valid = valid_r;

endmodule
`default_nettype wire
